[hw/rtl/ntfp_pkg.sv]
package ntfp_pkg;

  // fixed geometry of the parser
  localparam int unsigned MAX_NESTING   = 64;
  localparam int unsigned POSITION_BITS = 24;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned DEPTH_W = $clog2(MAX_NESTING);
  localparam int unsigned POS_W   = POSITION_BITS;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 8;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_VT     = 8'h0b;
  localparam logic [BYTE_W-1:0] CH_FF     = 8'h0c;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_DIG_LO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIG_HI = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UC_LO  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_HI  = 8'h5a;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5d;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5f;
  localparam logic [BYTE_W-1:0] CH_LC_LO  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_HI  = 8'h7a;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7d;

  typedef enum logic [EVENT_W-1:0] {
    EV_SKIP   = 4'd0,
    EV_NAME   = 4'd1,
    EV_QOPEN  = 4'd2,
    EV_SBYTE  = 4'd3,
    EV_QCLOSE = 4'd4,
    EV_OOPEN  = 4'd5,
    EV_LOPEN  = 4'd6,
    EV_OCLOSE = 4'd7,
    EV_LCLOSE = 4'd8,
    EV_OK     = 4'd9,
    EV_ERROR  = 4'd10,
    EV_HALTED = 4'd11
  } event_e;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    K_OTHER, K_SPACE, K_CR, K_LF, K_NAME, K_QUOTE,
    K_LBRACE, K_RBRACE, K_LBRACKET, K_RBRACKET, K_COMMENT
  } kind_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic is_obj;
  } stack_op_t;

  function automatic kind_e kind_of(input logic [BYTE_W-1:0] b);
    kind_e k;
    k = K_OTHER;
    if (b == CH_NUL || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_SPACE) begin
      k = K_SPACE;
    end else if (b == CH_CR) begin
      k = K_CR;
    end else if (b == CH_LF) begin
      k = K_LF;
    end else if ((b >= CH_DIG_LO && b <= CH_DIG_HI) || (b >= CH_UC_LO && b <= CH_UC_HI) ||
                 (b >= CH_LC_LO && b <= CH_LC_HI) || b == CH_UNDER) begin
      k = K_NAME;
    end else if (b == CH_QUOTE) begin
      k = K_QUOTE;
    end else if (b == CH_LBRACE) begin
      k = K_LBRACE;
    end else if (b == CH_RBRACE) begin
      k = K_RBRACE;
    end else if (b == CH_LBRACK) begin
      k = K_LBRACKET;
    end else if (b == CH_RBRACK) begin
      k = K_RBRACKET;
    end else if (b == CH_HASH) begin
      k = K_COMMENT;
    end
    return k;
  endfunction

endpackage

[hw/rtl/ntfp_stack.sv]
module ntfp_stack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntfp_pkg::stack_op_t               op_i,
  output logic [ntfp_pkg::DEPTH_W-1:0]      depth_o,
  output logic                              top_is_obj_o
);
  import ntfp_pkg::*;

  localparam int unsigned DW = DEPTH_W;

  logic          frame_mem [MAX_NESTING];
  logic [DW-1:0] dp_q, dp_d;
  logic          top_q, top_d;
  logic          below_q;

  always_comb begin
    dp_d  = dp_q;
    top_d = top_q;
    if (op_i.push) begin
      dp_d  = DW'(dp_q + 1'b1);
      top_d = op_i.is_obj;
    end else if (op_i.pop) begin
      dp_d  = DW'(dp_q - 1'b1);
      // the root frame is never written to the memory
      top_d = (dp_q == DW'(1)) ? 1'b1 : below_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q  <= '0;
      top_q <= 1'b1;
    end else begin
      dp_q  <= dp_d;
      top_q <= top_d;
    end
  end

  // frame flags, read ahead at the slot below the next top
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      frame_mem[DW'(dp_q + 1'b1)] <= op_i.is_obj;
    end
    below_q <= frame_mem[DW'(dp_d - 1'b1)];
  end

  assign depth_o      = dp_q;
  assign top_is_obj_o = top_q;

endmodule

[hw/rtl/nested_text_format_parser.sv]
// channel  | dir | signals                        | payload
// s_axis   | in  | tvalid tready tdata tlast      | tdata: text_byte; tlast: end_of_text
// m_axis   | out | tvalid tready tdata tuser      | tuser: event_res; tdata: token, pos
//
// one item per cycle sustained while the output is not stalled; each item is held in the input register
// and is then classified and applied to the parser state
// the frame stack is a memory read ahead at the slot one below the top
// reset clears all control state; the stack memory needs no clearing pass
// a stalled output register stops the input register, which takes one more item
module nested_text_format_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ntfp_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] text_byte
  input  logic                                s_axis_tlast,  // end_of_text
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] token_byte, [8] name_start, [14:9] nest_depth, [38:15] line_number,
  // [62:39] column_number, [63] zero
  output logic [ntfp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [ntfp_pkg::OUT_USER_W-1:0]     m_axis_tuser   // [3:0] event_res, [7:4] zero
);
  import ntfp_pkg::*;

  localparam int unsigned DW = DEPTH_W;
  localparam int unsigned PB = POS_W;

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_end_q;

  // parser state
  mode_e             mode_q, mode_d;
  logic              pcr_q, pcr_d;
  logic              thv_q, thv_d;
  logic              halt_q, halt_d;
  logic [PB-1:0]     line_q, line_d;
  logic [PB-1:0]     col_q, col_d;

  // output register
  logic              out_valid_q;
  event_e            ev_q;
  logic [BYTE_W-1:0] tok_q;
  logic              nstart_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [POS_W-1:0]  line_out_q;
  logic [POS_W-1:0]  col_out_q;

  logic              out_free, fire;
  stack_op_t         op, stack_op;
  logic [DW-1:0]     dp;
  logic              top_obj;
  logic [DW-1:0]     dp_next;

  event_e            ev;
  logic [BYTE_W-1:0] tok;
  logic              nstart;
  logic              done, fail;
  kind_e             kind;
  logic [PB-1:0]     col_adv;
  logic [PB-1:0]     line_adv;
  logic              full;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign stack_op = fire ? op : '0;

  ntfp_stack u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (stack_op),
    .depth_o     (dp),
    .top_is_obj_o(top_obj)
  );

  assign col_adv  = (col_q != '1) ? PB'(col_q + 1'b1) : col_q;
  assign line_adv = (line_q != '1) ? PB'(line_q + 1'b1) : line_q;
  assign full     = (dp == DW'(MAX_NESTING - 1));
  assign kind     = kind_of(in_byte_q);
  assign dp_next  = op.push ? DW'(dp + 1'b1) : (op.pop ? DW'(dp - 1'b1) : dp);

  always_comb begin
    ev     = EV_SKIP;
    tok    = '0;
    nstart = 1'b0;
    mode_d = mode_q;
    pcr_d  = pcr_q;
    thv_d  = thv_q;
    halt_d = halt_q;
    line_d = line_q;
    col_d  = col_q;
    op     = '0;
    done   = 1'b0;
    fail   = 1'b0;
    if (halt_q) begin
      ev = EV_HALTED;
    end else if (in_end_q) begin
      ev     = (mode_q == MODE_STRING || dp != '0) ? EV_ERROR : EV_OK;
      pcr_d  = 1'b0;
      halt_d = 1'b1;
    end else begin
      pcr_d = 1'b0;
      unique case (mode_q)
        MODE_STRING: begin
          done = 1'b1;
          if (in_byte_q == CH_QUOTE) begin
            ev     = EV_QCLOSE;
            mode_d = MODE_NORMAL;
            col_d  = col_adv;
          end else if (in_byte_q == CH_LF || in_byte_q == CH_CR) begin
            ev     = EV_ERROR;
            halt_d = 1'b1;
          end else begin
            ev    = EV_SBYTE;
            tok   = in_byte_q;
            col_d = col_adv;
          end
        end
        MODE_COMMENT: begin
          // a comment ends before a line break or a zero byte
          if (in_byte_q == CH_LF || in_byte_q == CH_CR || in_byte_q == CH_NUL) begin
            mode_d = MODE_NORMAL;
          end else begin
            done  = 1'b1;
            col_d = col_adv;
          end
        end
        MODE_NAME: begin
          if (kind == K_NAME) begin
            done  = 1'b1;
            ev    = EV_NAME;
            tok   = in_byte_q;
            col_d = col_adv;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end
        default: ;
      endcase
      if (!done) begin
        if (pcr_q && in_byte_q == CH_LF) begin
          // lf right after cr: same line break
          col_d = '0;
        end else begin
          unique case (kind)
            K_SPACE: col_d = col_adv;
            K_CR: begin
              line_d = line_adv;
              col_d  = '0;
              pcr_d  = 1'b1;
            end
            K_LF: begin
              line_d = line_adv;
              col_d  = '0;
            end
            K_NAME: begin
              if (!top_obj) begin
                fail = 1'b1;
              end else begin
                ev     = EV_NAME;
                tok    = in_byte_q;
                nstart = 1'b1;
                thv_d  = 1'b1;
                mode_d = MODE_NAME;
                col_d  = col_adv;
              end
            end
            K_QUOTE: begin
              if (!thv_q) begin
                fail = 1'b1;
              end else begin
                ev     = EV_QOPEN;
                mode_d = MODE_STRING;
                col_d  = col_adv;
              end
            end
            K_LBRACE, K_LBRACKET: begin
              if (!thv_q || full) begin
                fail = 1'b1;
              end else begin
                op.push   = 1'b1;
                op.is_obj = (kind == K_LBRACE);
                thv_d     = (kind != K_LBRACE);
                ev        = (kind == K_LBRACE) ? EV_OOPEN : EV_LOPEN;
                col_d     = col_adv;
              end
            end
            K_RBRACE: begin
              if (!top_obj || dp == '0) begin
                fail = 1'b1;
              end else begin
                op.pop = 1'b1;
                thv_d  = 1'b1;
                ev     = EV_OCLOSE;
                col_d  = col_adv;
              end
            end
            K_RBRACKET: begin
              if (top_obj || dp == '0) begin
                fail = 1'b1;
              end else begin
                op.pop = 1'b1;
                thv_d  = 1'b1;
                ev     = EV_LCLOSE;
                col_d  = col_adv;
              end
            end
            K_COMMENT: begin
              mode_d = MODE_COMMENT;
              col_d  = col_adv;
            end
            default: fail = 1'b1;
          endcase
        end
        if (fail) begin
          ev     = EV_ERROR;
          tok    = '0;
          nstart = 1'b0;
          halt_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_NORMAL;
      pcr_q       <= 1'b0;
      thv_q       <= 1'b0;
      halt_q      <= 1'b0;
      line_q      <= PB'(1);
      col_q       <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        pcr_q       <= pcr_d;
        thv_q       <= thv_d;
        halt_q      <= halt_d;
        line_q      <= line_d;
        col_q       <= col_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[BYTE_W-1:0];
      in_end_q  <= s_axis_tlast;
    end
    if (fire) begin
      ev_q       <= ev;
      tok_q      <= tok;
      nstart_q   <= nstart;
      depth_q    <= DEPTH_W'(dp_next);
      line_out_q <= POS_W'(line_q);
      col_out_q  <= POS_W'(col_adv);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, col_out_q, line_out_q, depth_q, nstart_q, tok_q};
  assign m_axis_tuser  = {(OUT_USER_W - EVENT_W)'(0), ev_q};

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halted state released");

  a_halt_no_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> !stack_op.push && !stack_op.pop)
    else $error("stack moved while halted");

  a_ok_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ev_q == EV_OK) |-> (dp == '0 && halt_q))
    else $error("ok reported away from root");

  a_name_start_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && nstart_q) |-> (mode_q == MODE_NAME && thv_q))
    else $error("name start without name mode");

endmodule
